// File: rtl/core/assert_macros.svh
// assertion helpers used by two_stack_fifo_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising clk edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tsq_pkg.sv
`timescale 1ns / 1ps

package tsq_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

// File: rtl/core/tsq_ram.sv
`timescale 1ns / 1ps

module tsq_ram
    import tsq_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// File: rtl/core/two_stack_fifo_queue.sv
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// input     | in_valid / in_stall       | func, value_in
// output    | out_valid / out_stall     | value_out, status
// config    | cfg_valid / cfg_ready     | cfg_data (capacity)
//
// enqueue: from acceptance through S_RESULT to a loaded output register
// dequeue, output stack not empty: S_POP, S_POP_WAIT, S_RESULT; an empty output
// stack first moves the whole input stack over, each entry via S_XFER_RD and
// S_XFER_WR, bounded by the single read port and registered read of each memory
// reset clears fill counts and control, loads capacity 64; memories not cleared
// output register holds its result under out_stall; a busy sequencer stalls input

`include "assert_macros.svh"

module two_stack_fifo_queue
    import tsq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic signed [DATA_W-1:0]   value_in,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   value_out,
    output logic [STATUS_W-1:0]        status,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CAP_W-1:0]           cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_XFER_RD,
        S_XFER_WR,
        S_POP,
        S_POP_WAIT,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic [CAP_W-1:0]      capacity_reg;
    logic [CW-1:0]         in_count_reg;
    logic [CW-1:0]         out_count_reg;
    logic [DATA_W-1:0]     res_value_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     value_out_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [KW-1:0]         cap_ext;
    logic [KW-1:0]         eff_k;
    logic [CW-1:0]         eff_cap;
    logic                  in_accept;
    logic                  out_free;

    logic                  in_we;
    logic [AW-1:0]         in_waddr;
    logic [AW-1:0]         in_raddr;
    logic [DATA_W-1:0]     in_rdata;
    logic                  out_we;
    logic [AW-1:0]         out_waddr;
    logic [AW-1:0]         out_raddr;
    logic [DATA_W-1:0]     out_rdata;
    logic [CW-1:0]         in_top;
    logic [CW-1:0]         out_top;

    // capacity saturates at the memory depth
    assign cap_ext = KW'(capacity_reg);
    assign eff_k   = (cap_ext > KW'(DEPTH)) ? KW'(DEPTH) : cap_ext;
    assign eff_cap = eff_k[CW-1:0];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == S_IDLE);

    assign in_top  = in_count_reg - CW'(1);
    assign out_top = out_count_reg - CW'(1);

    always_comb
    begin
        in_we     = in_accept && (func == FUNC_ENQ) && (in_count_reg < eff_cap);
        in_waddr  = in_count_reg[AW-1:0];
        in_raddr  = in_top[AW-1:0];
        out_we    = (state_reg == S_XFER_WR) && (out_count_reg < eff_cap);
        out_waddr = out_count_reg[AW-1:0];
        out_raddr = out_top[AW-1:0];
    end

    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_in_stack (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (value_in),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_out_stack (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (in_rdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            capacity_reg   <= CAP_RESET;
            in_count_reg   <= '0;
            out_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            res_value_reg  <= '0;
            res_status_reg <= ST_DONE;
            value_out_reg  <= '0;
            status_reg     <= ST_DONE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end

            if ((state_reg == S_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (func == FUNC_ENQ)
                        begin
                            res_value_reg <= '0;
                            if (in_count_reg < eff_cap)
                            begin
                                in_count_reg   <= in_count_reg + CW'(1);
                                res_status_reg <= ST_DONE;
                            end
                            else
                            begin
                                res_status_reg <= ST_FULL;
                            end
                            state_reg <= S_RESULT;
                        end
                        else if (out_count_reg == '0)
                        begin
                            state_reg <= S_XFER_RD;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                S_XFER_RD:
                begin
                    if (in_count_reg == '0)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        in_count_reg <= in_top;
                        state_reg    <= S_XFER_WR;
                    end
                end
                S_XFER_WR:
                begin
                    // entry is lost when the output stack is already full
                    if (out_count_reg < eff_cap)
                    begin
                        out_count_reg <= out_count_reg + CW'(1);
                    end
                    state_reg <= S_XFER_RD;
                end
                S_POP:
                begin
                    if (out_count_reg != '0)
                    begin
                        out_count_reg <= out_top;
                        state_reg     <= S_POP_WAIT;
                    end
                    else
                    begin
                        res_value_reg  <= EMPTY_VALUE;
                        res_status_reg <= ST_EMPTY;
                        state_reg      <= S_RESULT;
                    end
                end
                S_POP_WAIT:
                begin
                    res_value_reg  <= out_rdata;
                    res_status_reg <= ST_DONE;
                    state_reg      <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        value_out_reg <= res_value_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

    `ASSERT_CLK(a_in_count_bound, in_count_reg <= CW'(DEPTH), "input stack count above depth")
    `ASSERT_CLK(a_out_count_bound, out_count_reg <= CW'(DEPTH), "output stack count above depth")
    `ASSERT_IMPL(a_accept_busy, in_accept, ##1 (state_reg != S_IDLE), "no work after transaction")
    `ASSERT_IMPL(a_pop_dec, (state_reg == S_POP) && (out_count_reg != '0), ##1 (out_count_reg == $past(out_top)), "pop did not lower output count")
    `ASSERT_IMPL(a_out_from_result, $rose(out_valid_reg), $past(state_reg) == S_RESULT, "result shown outside result state")

endmodule

// File: tb/tb_two_stack_fifo_queue.sv
`timescale 1ns / 1ps

module tb_two_stack_fifo_queue;
    import tsq_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } queue_result_t;

    // two-stack queue predictor plus the results it still owes
    class tsq_scoreboard;
        logic [DATA_W-1:0] in_stack_q[DEPTH_DEF];
        logic [DATA_W-1:0] out_stack_q[DEPTH_DEF];
        int unsigned       in_fill;
        int unsigned       out_fill;
        logic [CAP_W-1:0]  capacity;
        queue_result_t     owed_results[$];
        int unsigned       mismatches;

        function new();
            in_fill    = 0;
            out_fill   = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(input logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // capacity saturates at the stack depth
        function int unsigned stack_room();
            return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
        endfunction

        function void note_request(input logic op, input logic [DATA_W-1:0] data);
            queue_result_t res;
            logic [DATA_W-1:0] moved;
            res.value  = '0;
            res.status = ST_DONE;
            if (op == FUNC_ENQ)
            begin
                if (in_fill < stack_room())
                begin
                    in_stack_q[in_fill] = data;
                    in_fill++;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            else
            begin
                if (out_fill == 0)
                begin
                    // refill reverses order; entries beyond room are lost
                    while (in_fill > 0)
                    begin
                        in_fill--;
                        moved = in_stack_q[in_fill];
                        if (out_fill < stack_room())
                        begin
                            out_stack_q[out_fill] = moved;
                            out_fill++;
                        end
                    end
                end
                if (out_fill > 0)
                begin
                    out_fill--;
                    res.value = out_stack_q[out_fill];
                end
                else
                begin
                    res.value  = EMPTY_VALUE;
                    res.status = ST_EMPTY;
                end
            end
            owed_results.push_back(res);
        endfunction

        task report_mismatch(input string msg);
            $display("error at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(input logic [DATA_W-1:0] got_value,
                            input logic [STATUS_W-1:0] got_status);
            queue_result_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d status %0d",
                                          $signed(got_value), got_status));
            end
            else
            begin
                want = owed_results.pop_front();
                if (got_value !== want.value)
                    report_mismatch($sformatf("value_out %0d, predicted %0d",
                                              $signed(got_value), $signed(want.value)));
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              got_status, want.status));
            end
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     func;
    logic signed [DATA_W-1:0] value_in;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] value_out;
    logic [STATUS_W-1:0]      status;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;

    tsq_scoreboard sb = new();
    int            sender_idle_pct;
    int            recv_stall_pct;
    int            cycle_count;

    two_stack_fifo_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_out (value_out),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: check each transaction, then pick the next stall
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_response(value_out, status);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // every task below starts and ends right after a rising edge
    task automatic send_item(input logic op, input logic [DATA_W-1:0] data);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            func     <= 1'($urandom_range(1));
            value_in <= $urandom();
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        func     <= op;
        value_in <= data;
        do @(posedge clk); while (in_stall);
        sb.note_request(op, data);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(cap);
    endtask

    // bursts of one operation so the stacks fill, drain and refill
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                             input int stall_pct, input int enq_pct, input int n_items);
        int unsigned sent;
        int unsigned burst;
        int unsigned room;
        logic        op;
        write_capacity(cap);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        room = (cap > DEPTH_DEF) ? DEPTH_DEF : cap;
        sent = 0;
        while (sent < n_items)
        begin
            op    = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            burst = $urandom_range(room + 3, 1);
            while (burst > 0 && sent < n_items)
            begin
                send_item(op, $urandom());
                sent++;
                burst--;
            end
            if ($urandom_range(15) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FUNC_ENQ;
        value_in  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= CAP_RESET;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, extreme values, order across a refill
        send_item(FUNC_DEQ, 32'h1234_5678);
        send_item(FUNC_ENQ, 32'h7FFF_FFFF);
        send_item(FUNC_ENQ, 32'h8000_0000);
        send_item(FUNC_ENQ, 32'h0000_0000);
        send_item(FUNC_ENQ, 32'hFFFF_FFFF);
        hold_until_drained();
        send_item(FUNC_DEQ, 32'hFFFF_FFFF);
        send_item(FUNC_DEQ, 32'h0000_0000);
        send_item(FUNC_ENQ, 32'h5555_5555);
        send_item(FUNC_DEQ, 32'hAAAA_AAAA);
        send_item(FUNC_DEQ, 32'h0000_0000);
        send_item(FUNC_DEQ, 32'h0000_0000);

        // single-entry stacks
        write_capacity(7'd1);
        send_item(FUNC_ENQ, 32'hAAAA_AAAA);
        send_item(FUNC_ENQ, 32'h5555_5555);
        send_item(FUNC_DEQ, 32'h0000_0000);
        send_item(FUNC_DEQ, 32'h0000_0000);

        // zero capacity holds nothing
        write_capacity(7'd0);
        send_item(FUNC_ENQ, 32'h0F0F_0F0F);
        send_item(FUNC_DEQ, 32'h0000_0000);

        // capacity lowered under a filled stack: entries kept, refill overflow lost
        write_capacity(7'd4);
        send_item(FUNC_ENQ, 32'h0000_0011);
        send_item(FUNC_ENQ, 32'h0000_0022);
        send_item(FUNC_ENQ, 32'h0000_0033);
        send_item(FUNC_ENQ, 32'h0000_0044);
        write_capacity(7'd2);
        send_item(FUNC_ENQ, 32'h0000_0055);
        send_item(FUNC_DEQ, 32'h0000_0000);
        send_item(FUNC_DEQ, 32'h0000_0000);
        send_item(FUNC_DEQ, 32'h0000_0000);

        run_phase(7'd64, 0, 0, 50, 60);
        run_phase(7'd3, 60, 0, 55, 50);
        run_phase(7'd127, 0, 60, 65, 80);
        run_phase(7'd1, 10, 10, 50, 40);
        run_phase(7'd65, 0, 0, 55, 50);
        run_phase(7'd0, 10, 10, 50, 20);
        run_phase(7'($urandom_range(16, 2)), 60, 0, 60, 50);
        run_phase(7'd2, 10, 10, 50, 50);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: two_stack_fifo_queue.f
+incdir+rtl/core
rtl/core/tsq_pkg.sv
rtl/core/tsq_ram.sv
rtl/core/two_stack_fifo_queue.sv
tb/tb_two_stack_fifo_queue.sv
